[rtl/core/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Types, codes and sizes shared by the power sequencer modules.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_NODES = 16;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = 5;
  localparam int TIME_W    = 32;
  localparam int RB_DEPTH  = 34;
  localparam int RB_AW     = 6;
  localparam int PADDR_W   = 3;

  localparam logic [2:0] OP_REG  = 3'd0;
  localparam logic [2:0] OP_SHUT = 3'd1;
  localparam logic [2:0] OP_CUT  = 3'd2;
  localparam logic [2:0] OP_BOOT = 3'd3;
  localparam logic [2:0] OP_TICK = 3'd4;

  localparam logic [3:0] EV_REGD     = 4'd0;
  localparam logic [3:0] EV_DUP      = 4'd1;
  localparam logic [3:0] EV_FULL     = 4'd2;
  localparam logic [3:0] EV_REJ      = 4'd3;
  localparam logic [3:0] EV_SHUT     = 4'd4;
  localparam logic [3:0] EV_DN_START = 4'd5;
  localparam logic [3:0] EV_DN_DONE  = 4'd6;
  localparam logic [3:0] EV_CUT      = 4'd7;
  localparam logic [3:0] EV_OFF      = 4'd8;
  localparam logic [3:0] EV_BOOT     = 4'd9;
  localparam logic [3:0] EV_UP_START = 4'd10;
  localparam logic [3:0] EV_UP_DONE  = 4'd11;
  localparam logic [3:0] EV_ON       = 4'd12;

  localparam logic [1:0] MODE_ON   = 2'd0;
  localparam logic [1:0] MODE_DOWN = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;
  localparam logic [1:0] MODE_BOOT = 2'd3;

  localparam logic [0:0] REG_BOOT_DELAY = 1'b0;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now;
    logic [15:0] node_id;
    logic [2:0]  priority_req;
    logic [31:0] batt_life;
    logic [15:0] fail_mask;
  } in_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [15:0] node_id_res;
    logic        node_valid;
    logic [31:0] time_res;
    logic        clean;
    logic        forced;
    logic [31:0] detail_value;
    logic [1:0]  system_state;
    logic [15:0] graceful_count;
    logic [15:0] cutoff_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [3:0]  ev;
    logic [15:0] id;
    logic        valid;
    logic        clean;
    logic        forced;
  } rec_t;

  typedef struct packed {
    logic             we;
    logic [RB_AW-1:0] waddr;
    rec_t             wdata;
    logic [RB_AW-1:0] raddr;
  } rb_ctl_t;

  typedef enum logic [2:0] {
    WK_SCHED = 3'd0,
    WK_BOOT  = 3'd1,
    WK_CUT   = 3'd2,
    WK_DOWN  = 3'd3,
    WK_UP    = 3'd4
  } walk_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DEC    = 9'b000000010,
    ST_SEARCH = 9'b000000100,
    ST_ADD    = 9'b000001000,
    ST_DIV    = 9'b000010000,
    ST_WALK   = 9'b000100000,
    ST_FIN    = 9'b001000000,
    ST_DRD    = 9'b010000000,
    ST_DWR    = 9'b100000000
  } state_t;

endpackage

[rtl/core/pps_div.sv]
// ----------------------------------------------------------------------------
// pps_div
// Restoring divider, one quotient bit per cycle, 32-bit by 4-bit.
// ----------------------------------------------------------------------------
module pps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [3:0]  divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import pps_pkg::*;

  logic [31:0] q_r, q_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [3:0]  d_r, d_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  trial;
  logic        ge;

  always_comb begin
    trial    = {rem_r, q_r[31]};
    ge       = trial >= {1'b0, d_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? 4'(trial - {1'b0, d_r}) : trial[3:0];
      q_nxt   = {q_r[30:0], ge};
      cnt_nxt = 5'(cnt_r + 5'd1);
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[rtl/core/pps_rbuf.sv]
// ----------------------------------------------------------------------------
// pps_rbuf
// Event record buffer; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pps_rbuf (
  input  logic            clk,
  input  pps_pkg::rb_ctl_t ctl,
  output pps_pkg::rec_t   rdata
);
  import pps_pkg::*;

  rec_t mem [RB_DEPTH];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rdata_r <= mem[ctl.raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/priority_power_sequencer.sv]
// ----------------------------------------------------------------------------
// priority_power_sequencer
// Priority-ordered shutdown, cutoff and boot sequencing of a node table.
// ----------------------------------------------------------------------------
// One request at a time; in_stall is high from acceptance until the last
// event record is handed off, or until the request ends if it makes none.
// Records are collected in a buffer and then sent one by one, each read
// from the buffer (ST_DRD) and then registered out (ST_DWR). A walk over the
// table visits the eight priority levels in turn and at each present level
// scans every registered node; in a staged shutdown or boot a node that
// changes state gets its second record in a step of its own. Start shutdown
// first runs the divider when any level is present. Register first searches
// the table for the id when the table is not empty, then adds the node.
module priority_power_sequencer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pps_pkg::in_t          in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pps_pkg::out_t         out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [pps_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import pps_pkg::*;

  state_t state_r, state_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]  present_r, present_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] life_r, life_nxt;
  logic [15:0] grace_r, grace_nxt;
  logic [15:0] cut_r, cut_nxt;
  logic [31:0] delay_r;
  in_t         req_r;

  logic [15:0] ids_r [MAX_NODES];
  logic [2:0]  pri_r [MAX_NODES];
  logic        on_r  [MAX_NODES];
  logic [31:0] due_r [MAX_NODES];

  walk_t       wk_r, wk_nxt;
  logic [2:0]  p_r, p_nxt;
  logic [SLOT_W-1:0] s_r, s_nxt;
  logic        pend_r, pend_nxt;
  logic        all_r, all_nxt;
  logic        gfirst_r, gfirst_nxt;
  logic [35:0] acc_r, acc_nxt;
  logic [31:0] inc_r, inc_nxt;
  logic [RB_AW-1:0] nres_r, nres_nxt;
  logic [RB_AW-1:0] rd_r, rd_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;

  logic        add_we, due_we, on_we, on_wd;
  logic [31:0] due_wd;

  logic        div_start, div_done;
  logic [31:0] div_q;
  rb_ctl_t     rb;
  rec_t        rb_q;

  logic        asc, slot_hit, slot_end, p_end, out_free, time_due;
  logic [31:0] elapsed, acc_sat;

  pps_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(req_r.batt_life),
    .divisor(4'($countones(present_r) + 1)), .done(div_done), .quotient(div_q)
  );

  pps_rbuf u_rbuf (.clk(clk), .ctl(rb), .rdata(rb_q));

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BOOT_DELAY) ? delay_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= 32'd1000;
    end else if (psel && penable && pwrite && paddr[2] == REG_BOOT_DELAY) begin
      delay_r <= pwdata;
    end
  end

  always_comb begin
    asc      = (wk_r == WK_SCHED) || (wk_r == WK_CUT) || (wk_r == WK_DOWN);
    slot_hit = pri_r[s_r] == p_r;
    slot_end = {1'b0, s_r} == 5'(cnt_r - 5'd1);
    p_end    = asc ? (p_r == 3'd7) : (p_r == 3'd0);
    out_free = !out_valid_r || !out_stall;
    time_due = req_r.now >= due_r[s_r];
    elapsed  = (req_r.now >= start_r) ? 32'(req_r.now - start_r) : 32'd0;
    acc_sat  = (acc_r[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_r[31:0];
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    present_nxt = present_r;
    start_nxt   = start_r;
    life_nxt    = life_r;
    grace_nxt   = grace_r;
    cut_nxt     = cut_r;
    wk_nxt      = wk_r;
    p_nxt       = p_r;
    s_nxt       = s_r;
    pend_nxt    = pend_r;
    all_nxt     = all_r;
    gfirst_nxt  = gfirst_r;
    acc_nxt     = acc_r;
    inc_nxt     = inc_r;
    nres_nxt    = nres_r;
    rd_nxt      = rd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt     = out_r;
    add_we      = 1'b0;
    due_we      = 1'b0;
    due_wd      = acc_sat;
    on_we       = 1'b0;
    on_wd       = 1'b0;
    div_start   = 1'b0;
    rb.we       = 1'b0;
    rb.waddr    = nres_r;
    rb.wdata    = '0;
    rb.raddr    = rd_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DEC;
          nres_nxt  = '0;
          rd_nxt    = '0;
        end
      end
      ST_DEC: begin
        state_nxt  = ST_DRD;
        p_nxt      = 3'd0;
        s_nxt      = '0;
        pend_nxt   = 1'b0;
        gfirst_nxt = 1'b1;
        all_nxt    = 1'b1;
        acc_nxt    = {4'd0, req_r.now};
        rb.wdata.ev = EV_REJ;
        unique case (req_r.op)
          OP_REG: begin
            state_nxt = (cnt_r == '0) ? ST_ADD : ST_SEARCH;
          end
          OP_SHUT: begin
            rb.we = 1'b1;
            if (mode_r == MODE_ON) begin
              rb.wdata.ev = EV_SHUT;
              mode_nxt    = MODE_DOWN;
              start_nxt   = req_r.now;
              life_nxt    = req_r.batt_life;
              if (present_r != 8'd0) begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
          end
          OP_CUT: begin
            if (mode_r == MODE_OFF) begin
              rb.we = 1'b1;
            end else begin
              wk_nxt    = WK_CUT;
              state_nxt = ST_WALK;
            end
          end
          OP_BOOT: begin
            rb.we = 1'b1;
            if (mode_r == MODE_OFF) begin
              rb.wdata.ev = EV_BOOT;
              mode_nxt    = MODE_BOOT;
              wk_nxt      = WK_BOOT;
              inc_nxt     = delay_r;
              p_nxt       = 3'd7;
              state_nxt   = ST_WALK;
            end
          end
          OP_TICK: begin
            if (mode_r == MODE_DOWN) begin
              wk_nxt    = (elapsed >= life_r) ? WK_CUT : WK_DOWN;
              state_nxt = ST_WALK;
            end else if (mode_r == MODE_BOOT) begin
              wk_nxt    = WK_UP;
              p_nxt     = 3'd7;
              state_nxt = ST_WALK;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            rb.we = 1'b1;
          end
        endcase
        if (rb.we) begin
          nres_nxt = 6'(nres_r + 6'd1);
        end
      end
      ST_SEARCH: begin
        if (ids_r[s_r] == req_r.node_id) begin
          rb.we       = 1'b1;
          rb.wdata.ev = EV_DUP;
          rb.wdata.id = req_r.node_id;
          rb.wdata.valid = 1'b1;
          nres_nxt    = 6'(nres_r + 6'd1);
          state_nxt   = ST_DRD;
        end else if (slot_end) begin
          state_nxt = ST_ADD;
        end else begin
          s_nxt = 4'(s_r + 4'd1);
        end
      end
      ST_ADD: begin
        rb.we          = 1'b1;
        rb.wdata.id    = req_r.node_id;
        rb.wdata.valid = 1'b1;
        nres_nxt       = 6'(nres_r + 6'd1);
        state_nxt      = ST_DRD;
        if (cnt_r[CNT_W-1]) begin
          rb.wdata.ev = EV_FULL;
        end else begin
          rb.wdata.ev = EV_REGD;
          add_we      = 1'b1;
          cnt_nxt     = 5'(cnt_r + 5'd1);
          present_nxt = present_r | (8'd1 << req_r.priority_req);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          inc_nxt   = div_q;
          wk_nxt    = WK_SCHED;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (pend_r) begin
          rb.we          = 1'b1;
          rb.wdata.id    = ids_r[s_r];
          rb.wdata.valid = 1'b1;
          nres_nxt       = 6'(nres_r + 6'd1);
          pend_nxt       = 1'b0;
          if (wk_r == WK_DOWN) begin
            rb.wdata.ev    = EV_DN_DONE;
            rb.wdata.clean = !req_r.fail_mask[s_r];
          end else begin
            rb.wdata.ev = EV_UP_DONE;
          end
        end else if (!present_r[p_r]) begin
          // nothing at this level
        end else if (gfirst_r) begin
          gfirst_nxt = 1'b0;
          acc_nxt    = 36'(acc_r + {4'd0, inc_r});
        end else if (slot_hit) begin
          unique case (wk_r)
            WK_SCHED, WK_BOOT: begin
              due_we = 1'b1;
            end
            WK_CUT: begin
              if (on_r[s_r]) begin
                on_we          = 1'b1;
                rb.we          = 1'b1;
                rb.wdata.ev    = EV_CUT;
                rb.wdata.id    = ids_r[s_r];
                rb.wdata.valid = 1'b1;
                nres_nxt       = 6'(nres_r + 6'd1);
                if (cut_r != 16'hFFFF) cut_nxt = 16'(cut_r + 16'd1);
              end
            end
            WK_DOWN: begin
              if (on_r[s_r] && time_due) begin
                on_we          = 1'b1;
                rb.we          = 1'b1;
                rb.wdata.ev    = EV_DN_START;
                rb.wdata.id    = ids_r[s_r];
                rb.wdata.valid = 1'b1;
                nres_nxt       = 6'(nres_r + 6'd1);
                pend_nxt       = 1'b1;
                if (grace_r != 16'hFFFF) grace_nxt = 16'(grace_r + 16'd1);
              end else if (on_r[s_r]) begin
                all_nxt = 1'b0;
              end
            end
            default: begin
              if (!on_r[s_r] && time_due) begin
                on_we          = 1'b1;
                on_wd          = 1'b1;
                rb.we          = 1'b1;
                rb.wdata.ev    = EV_UP_START;
                rb.wdata.id    = ids_r[s_r];
                rb.wdata.valid = 1'b1;
                nres_nxt       = 6'(nres_r + 6'd1);
                pend_nxt       = 1'b1;
              end else if (!on_r[s_r]) begin
                all_nxt = 1'b0;
              end
            end
          endcase
        end
        // advance unless a second record is still owed for this slot, or this is the first step at a present level
        if (!pend_nxt && !(present_r[p_r] && gfirst_r && !pend_r)) begin
          if (!present_r[p_r] || slot_end) begin
            s_nxt      = '0;
            gfirst_nxt = 1'b1;
            if (p_end) begin
              state_nxt = ST_FIN;
            end else begin
              p_nxt = asc ? 3'(p_r + 3'd1) : 3'(p_r - 3'd1);
            end
          end else begin
            s_nxt = 4'(s_r + 4'd1);
          end
        end
      end
      ST_FIN: begin
        state_nxt = (nres_r == '0) ? ST_IDLE : ST_DRD;
        if (wk_r == WK_CUT || (wk_r == WK_DOWN && all_r)) begin
          rb.we          = 1'b1;
          rb.wdata.ev    = EV_OFF;
          rb.wdata.forced = wk_r == WK_CUT;
          nres_nxt       = 6'(nres_r + 6'd1);
          mode_nxt       = MODE_OFF;
          state_nxt      = ST_DRD;
        end else if (wk_r == WK_UP && all_r) begin
          rb.we       = 1'b1;
          rb.wdata.ev = EV_ON;
          nres_nxt    = 6'(nres_r + 6'd1);
          mode_nxt    = MODE_ON;
          state_nxt   = ST_DRD;
        end
      end
      ST_DRD: begin
        state_nxt = ST_DWR;
      end
      ST_DWR: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.event_res      = rb_q.ev;
          out_nxt.node_id_res    = rb_q.id;
          out_nxt.node_valid     = rb_q.valid;
          out_nxt.time_res       = req_r.now;
          out_nxt.clean          = rb_q.clean;
          out_nxt.forced         = rb_q.forced;
          out_nxt.detail_value   = (rb_q.ev == EV_SHUT) ? req_r.batt_life : 32'd0;
          out_nxt.system_state   = mode_r;
          out_nxt.graceful_count = grace_r;
          out_nxt.cutoff_count   = cut_r;
          out_nxt.last           = 6'(rd_r + 6'd1) == nres_r;
          rd_nxt                 = 6'(rd_r + 6'd1);
          state_nxt              = out_nxt.last ? ST_IDLE : ST_DRD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_r <= in_data;
    end
    if (add_we) begin
      ids_r[cnt_r[SLOT_W-1:0]] <= req_r.node_id;
      pri_r[cnt_r[SLOT_W-1:0]] <= req_r.priority_req;
      on_r[cnt_r[SLOT_W-1:0]]  <= mode_r == MODE_ON;
      due_r[cnt_r[SLOT_W-1:0]] <= 32'd0;
    end
    if (due_we) begin
      due_r[s_r] <= due_wd;
    end
    if (on_we) begin
      on_r[s_r] <= on_wd;
    end
    wk_r     <= wk_nxt;
    p_r      <= p_nxt;
    s_r      <= s_nxt;
    pend_r   <= pend_nxt;
    all_r    <= all_nxt;
    gfirst_r <= gfirst_nxt;
    acc_r    <= acc_nxt;
    inc_r    <= inc_nxt;
    nres_r   <= nres_nxt;
    rd_r     <= rd_nxt;
    out_r    <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_ON;
      cnt_r       <= '0;
      present_r   <= '0;
      start_r     <= '0;
      life_r      <= '0;
      grace_r     <= '0;
      cut_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      present_r   <= present_nxt;
      start_r     <= start_nxt;
      life_r      <= life_nxt;
      grace_r     <= grace_nxt;
      cut_r       <= cut_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for priority_power_sequencer. Requests are predicted
// by a model of the node table (registration, staged shutdown, cutoff,
// staged boot) kept in a small scoreboard class. Event records from the
// block are compared in order with the predicted ones. The input idles and
// the output stalls at random, and the boot delay register is swept between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pps_pkg::*;

  localparam logic [31:0] TMAX = 32'hFFFF_FFFF;

  class power_board;
    logic [31:0] boot_delay;
    logic [1:0]  mode;
    int          count;
    logic [15:0] ids [MAX_NODES];
    logic [2:0]  prio [MAX_NODES];
    bit          up [MAX_NODES];
    logic [31:0] due [MAX_NODES];
    logic [31:0] shut_at;
    logic [31:0] life;
    logic [15:0] graceful;
    logic [15:0] cuts;
    out_t        fresh [$];
    out_t        events_due [$];
    int          errors;

    function new();
      boot_delay = 32'd1000;
      mode = MODE_ON;
      count = 0;
      shut_at = '0;
      life = '0;
      graceful = '0;
      cuts = '0;
      errors = 0;
    endfunction

    function void emit(logic [3:0] ev, logic [15:0] id, bit valid, logic [31:0] t,
                       bit cl, bit fc, logic [31:0] det);
      out_t r;
      r = '0;
      r.event_res = ev;
      r.node_id_res = valid ? id : 16'd0;
      r.node_valid = valid;
      r.time_res = t;
      r.clean = cl;
      r.forced = fc;
      r.detail_value = det;
      fresh.insert(fresh.size(), r);
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [63:0] b);
      logic [63:0] s;
      s = {32'd0, a} + b;
      return (s > {32'd0, TMAX}) ? TMAX : s[31:0];
    endfunction

    function void walk_order(bit descending, ref int ord[$]);
      int p;
      ord.delete();
      for (int k = 0; k < 8; k++) begin
        p = descending ? 7 - k : k;
        for (int i = 0; i < count; i++)
          if (prio[i] == p) ord.insert(ord.size(), i);
      end
    endfunction

    function void cut_all(logic [31:0] t);
      int ord[$];
      walk_order(0, ord);
      foreach (ord[k]) begin
        if (up[ord[k]]) begin
          up[ord[k]] = 0;
          if (cuts != 16'hFFFF) cuts++;
          emit(EV_CUT, ids[ord[k]], 1, t, 0, 0, 0);
        end
      end
      mode = MODE_OFF;
      emit(EV_OFF, 0, 0, t, 0, 1, 0);
    endfunction

    function void note_request(in_t d);
      logic [7:0]  present;
      int          groups, below, rank;
      logic [31:0] spacing, elapsed;
      bit          dup, all_done, failed;
      int          ord[$];
      present = '0;
      for (int i = 0; i < count; i++) present[prio[i]] = 1;
      groups = $countones(present);
      fresh.delete();
      case (d.op)
        OP_REG: begin
          dup = 0;
          for (int i = 0; i < count; i++) if (ids[i] == d.node_id) dup = 1;
          if (dup) emit(EV_DUP, d.node_id, 1, d.now, 0, 0, 0);
          else if (count >= MAX_NODES) emit(EV_FULL, d.node_id, 1, d.now, 0, 0, 0);
          else begin
            ids[count] = d.node_id;
            prio[count] = d.priority_req;
            up[count] = (mode == MODE_ON);
            due[count] = '0;
            count++;
            emit(EV_REGD, d.node_id, 1, d.now, 0, 0, 0);
          end
        end
        OP_SHUT: begin
          if (mode != MODE_ON) emit(EV_REJ, 0, 0, d.now, 0, 0, 0);
          else begin
            mode = MODE_DOWN;
            shut_at = d.now;
            life = d.batt_life;
            emit(EV_SHUT, 0, 0, d.now, 0, 0, d.batt_life);
            if (groups != 0) begin
              spacing = d.batt_life / (groups + 1);
              for (int i = 0; i < count; i++) begin
                below = 0;
                for (int p = 0; p < prio[i]; p++) if (present[p]) below++;
                due[i] = sat_add(d.now, 64'(spacing) * (below + 1));
              end
            end
          end
        end
        OP_CUT: begin
          if (mode == MODE_OFF) emit(EV_REJ, 0, 0, d.now, 0, 0, 0);
          else cut_all(d.now);
        end
        OP_BOOT: begin
          if (mode != MODE_OFF) emit(EV_REJ, 0, 0, d.now, 0, 0, 0);
          else begin
            mode = MODE_BOOT;
            emit(EV_BOOT, 0, 0, d.now, 0, 0, 0);
            for (int i = 0; i < count; i++) begin
              rank = 0;
              for (int p = prio[i]; p < 8; p++) if (present[p]) rank++;
              due[i] = sat_add(d.now, 64'(boot_delay) * rank);
            end
          end
        end
        OP_TICK: begin
          all_done = 1;
          if (mode == MODE_DOWN) begin
            elapsed = (d.now >= shut_at) ? d.now - shut_at : 32'd0;
            if (elapsed >= life) cut_all(d.now);
            else begin
              walk_order(0, ord);
              foreach (ord[k]) begin
                if (up[ord[k]] && d.now >= due[ord[k]]) begin
                  failed = d.fail_mask[ord[k]];
                  emit(EV_DN_START, ids[ord[k]], 1, d.now, 0, 0, 0);
                  up[ord[k]] = 0;
                  if (graceful != 16'hFFFF) graceful++;
                  emit(EV_DN_DONE, ids[ord[k]], 1, d.now, !failed, 0, 0);
                end
                if (up[ord[k]]) all_done = 0;
              end
              if (all_done) begin
                mode = MODE_OFF;
                emit(EV_OFF, 0, 0, d.now, 0, 0, 0);
              end
            end
          end else if (mode == MODE_BOOT) begin
            walk_order(1, ord);
            foreach (ord[k]) begin
              if (!up[ord[k]] && d.now >= due[ord[k]]) begin
                emit(EV_UP_START, ids[ord[k]], 1, d.now, 0, 0, 0);
                up[ord[k]] = 1;
                emit(EV_UP_DONE, ids[ord[k]], 1, d.now, 0, 0, 0);
              end
              if (!up[ord[k]]) all_done = 0;
            end
            if (all_done) begin
              mode = MODE_ON;
              emit(EV_ON, 0, 0, d.now, 0, 0, 0);
            end
          end
        end
        default: emit(EV_REJ, 0, 0, d.now, 0, 0, 0);
      endcase
      foreach (fresh[k]) begin
        fresh[k].system_state = mode;
        fresh[k].graceful_count = graceful;
        fresh[k].cutoff_count = cuts;
        fresh[k].last = (k == fresh.size() - 1);
        events_due.insert(events_due.size(), fresh[k]);
      end
    endfunction

    function void check_event(out_t got);
      out_t want;
      if (events_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected event record %p", got);
        return;
      end
      want = events_due.pop_front();
      if (got.event_res !== want.event_res || got.node_id_res !== want.node_id_res ||
          got.node_valid !== want.node_valid || got.time_res !== want.time_res ||
          got.clean !== want.clean || got.forced !== want.forced ||
          got.detail_value !== want.detail_value ||
          got.system_state !== want.system_state ||
          got.graceful_count !== want.graceful_count ||
          got.cutoff_count !== want.cutoff_count || got.last !== want.last) begin
        errors++;
        if (errors <= 10) $display("event mismatch\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  power_board board = new();
  logic [31:0] clock_ms;
  bit   hold_go = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   calm_left = 0;

  priority_power_sequencer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_event(out_data);
    if (hold_go) begin
      hold_go = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
      case ($urandom_range(0, 9))
        0: calm_left = $urandom_range(20, 80);
        1, 2: stall_left = $urandom_range(1, 3);
        3: stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : 1;
        default: ;
      endcase
    end
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_request(in_t d);
    int gap;
    in_valid <= 1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    board.note_request(d);
    gap = ($urandom_range(0, 2) == 0) ? 0 :
          ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic request(logic [2:0] op, logic [31:0] t, logic [15:0] id = 0,
                         logic [2:0] pr = 0, logic [31:0] bl = 0,
                         logic [15:0] fm = 0);
    in_t d;
    d.op = op;
    d.now = t;
    d.node_id = id;
    d.priority_req = pr;
    d.batt_life = bl;
    d.fail_mask = fm;
    send_request(d);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (board.events_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_boot_delay(logic [31:0] v);
    drain();
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= PADDR_W'(REG_BOOT_DELAY) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.boot_delay = v;
  endtask

  function automatic logic [31:0] advance(logic [31:0] step);
    clock_ms = board.sat_add(clock_ms, step);
    return clock_ms;
  endfunction

  task automatic random_noise;
    in_t d;
    d.op = 3'($urandom);
    d.now = $urandom;
    d.node_id = 16'($urandom);
    d.priority_req = 3'($urandom);
    d.batt_life = $urandom;
    d.fail_mask = 16'($urandom);
    if ($urandom_range(0, 1)) d.op = 3'($urandom_range(0, 4));
    if ($urandom_range(0, 3) != 0) d.now = advance($urandom_range(0, 500));
    send_request(d);
  endtask

  task automatic shutdown_episode(ref int sent);
    logic [31:0] bl;
    int n;
    n = $urandom_range(0, 3);
    repeat (n) begin
      request(OP_REG, advance($urandom_range(0, 50)),
              ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 20)) : 16'($urandom),
              3'($urandom_range(0, 7)));
      sent++;
    end
    case ($urandom_range(0, 9))
      0: bl = 0;
      1: bl = TMAX;
      2: bl = $urandom;
      default: bl = $urandom_range(100, 8000);
    endcase
    request(OP_SHUT, advance($urandom_range(0, 100)), 0, 0, bl);
    sent++;
    n = $urandom_range(2, 10);
    while (n > 0 && board.mode == MODE_DOWN) begin
      if ($urandom_range(0, 14) == 0) request(OP_CUT, advance(1));
      else request(OP_TICK, advance((bl == TMAX || bl == 0) ? $urandom :
                   $urandom_range(0, bl / 3 + 1)), 0, 0, 0,
                   ($urandom_range(0, 1) ? 16'($urandom) : 16'd0));
      sent++;
      n--;
    end
  endtask

  task automatic boot_episode(ref int sent);
    int n;
    if ($urandom_range(0, 2) == 0) begin
      request(OP_REG, advance(1), 16'($urandom), 3'($urandom_range(0, 7)));
      sent++;
    end
    request(OP_BOOT, advance($urandom_range(0, 100)));
    sent++;
    n = $urandom_range(2, 10);
    while (n > 0 && board.mode == MODE_BOOT) begin
      case ($urandom_range(0, 9))
        0: request(OP_CUT, advance(0));
        1: request(OP_TICK, advance(TMAX));
        default: request(OP_TICK, advance(($urandom_range(0, 1) &&
                         board.boot_delay < 32'd100000) ? board.boot_delay :
                         $urandom_range(0, 1500)));
      endcase
      sent++;
      n--;
    end
  endtask

  initial begin
    int sent;
    logic [31:0] delays [4];
    delays = '{32'd0, TMAX, 32'd1, 32'd250};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty table paths, unknown ops, wrong-state rejects, a duplicate id and extreme times
    request(OP_SHUT, 0, 0, 0, 1000);
    request(OP_TICK, 10);
    request(OP_BOOT, 20);
    request(OP_TICK, 30);
    request(3'd5, 31);
    request(3'd6, 32);
    request(3'd7, 33);
    request(OP_CUT, 40);
    request(OP_CUT, 41);
    request(OP_SHUT, 42, 0, 0, 5);
    request(OP_BOOT, 50);
    request(OP_TICK, 60);
    request(OP_REG, 70, 16'h0000, 3'd0);
    request(OP_REG, 71, 16'hFFFF, 3'd7);
    request(OP_REG, 72, 16'h1234, 3'd3);
    request(OP_REG, 73, 16'h1234, 3'd5);
    request(OP_REG, 74, 16'h0005, 3'd3);
    request(OP_BOOT, 75);
    request(OP_SHUT, 100, 0, 0, TMAX);
    request(OP_TICK, 50, 0, 0, 0, 16'hFFFF);
    request(OP_TICK, 32'hFFFF_FFFE, 0, 0, 0, 16'hFFFF);
    request(OP_CUT, TMAX);
    request(OP_BOOT, TMAX);
    request(OP_TICK, TMAX, 0, 0, 0, 16'hA5A5);

    clock_ms = 32'd1000;
    sent = 0;
    hold_go = 1;
    for (int phase = 0; phase < 4; phase++) begin
      write_boot_delay(delays[phase]);
      while (sent < 100 * (phase + 1)) begin
        if ($urandom_range(0, 6) == 0) begin
          random_noise();
          sent++;
        end else if (board.mode == MODE_ON) shutdown_episode(sent);
        else if (board.mode == MODE_OFF) boot_episode(sent);
        else begin
          request(OP_CUT, advance($urandom_range(0, 10)));
          sent++;
        end
        if ($urandom_range(0, 29) == 0) clock_ms = $urandom;
      end
    end

    drain();
    if (board.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
rtl/core/pps_pkg.sv
rtl/core/pps_div.sv
rtl/core/pps_rbuf.sv
rtl/core/priority_power_sequencer.sv
bench/tb.sv
